// ===== hw/rtl/pdc_pkg.sv =====
// pdc_pkg: shared widths, register indexes and reset values for the pid drive
// used by pid_drive_with_clamps and pdc_scale; no dependencies
`timescale 1ns / 1ps

package pdc_pkg;

  localparam int DATA_W  = 32;             // set point and measurement width
  localparam int ERR_W   = DATA_W + 1;     // error, difference, integral sum
  localparam int TENT_W  = ERR_W + 1;      // tentative sum and limit compares
  localparam int GAIN_W  = 16;             // unsigned q0.16 gains
  localparam int LIM_W   = 31;             // limit and saturation registers
  localparam int DRIVE_W = 16;             // output drive, q8 degrees
  localparam int PROD_W  = ERR_W + GAIN_W; // magnitude times gain
  localparam int TERM_W  = ERR_W + 3;      // signed term and three-term total
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_ERROR_LIMIT = 3'd3,
    REG_SUM_LIMIT   = 3'd4,
    REG_PROP_SAT    = 3'd5,
    REG_INTEG_SAT   = 3'd6,
    REG_DRIVE_MAX   = 3'd7
  } cfg_reg_t;

  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST   = 16'd4588;
  localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST  = 16'd1966;
  localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST  = 16'd6554;
  localparam logic [LIM_W-1:0]   ERROR_LIMIT_RST = 31'd117440512;
  localparam logic [LIM_W-1:0]   SUM_LIMIT_RST   = 31'd50331648;
  localparam logic [LIM_W-1:0]   PROP_SAT_RST    = 31'd16777216;
  localparam logic [LIM_W-1:0]   INTEG_SAT_RST   = 31'd8388608;
  localparam logic [DRIVE_W-1:0] DRIVE_MAX_RST   = 16'd46080;

  // one half lsb of the q0.16 gain product, for round to nearest
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (GAIN_W - 1);

endpackage

// ===== hw/rtl/pid_drive_with_clamps.sv =====
// pid_drive_with_clamps: pid servo drive with error, integral and output clamps
// depends on pdc_pkg and pdc_scale
`timescale 1ns / 1ps

// channel | direction | handshake           | payload
// --------+-----------+---------------------+------------------------------------
// in      | input     | in_valid / in_ready | set_point, measured (signed q8)
// out     | output    | out_valid/out_ready | drive (unsigned q8 degrees)
// cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data (always ready)
//
// one sample per cycle sustained while the output is not stalled; a result passes
// through three register stages: state update, gain multiplies, sum and clamp
// the integral sum and last measurement update in the transfer cycle, so the
// next sample can follow at once
// synchronous reset restores register defaults and clears sum and history
// each stage moves when empty or when the stage after it moves, so input is
// taken while a finished result waits as long as some stage is free

module pid_drive_with_clamps import pdc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [DATA_W-1:0]     set_point,
  input  logic [DATA_W-1:0]     measured,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DRIVE_W-1:0]    drive,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic [GAIN_W-1:0]  prop_gain, integ_gain, deriv_gain;
  logic [LIM_W-1:0]   error_limit, sum_limit, prop_saturation, integ_saturation;
  logic [DRIVE_W-1:0] drive_max;

  // controller state
  logic signed [ERR_W-1:0]  integral_sum, integral_sum_next;
  logic signed [DATA_W-1:0] last_measured;

  // stage 1: error, old sum, measurement difference, saturation flags
  logic                    v1;
  logic signed [ERR_W-1:0] s1_err, s1_sum, s1_diff;
  logic                    s1_p_hi, s1_p_lo, s1_i_hi, s1_i_lo;

  // stage 2: rounded term magnitudes and signs
  logic                    v2;
  logic [ERR_W-1:0]        s2_p_mag, s2_i_mag, s2_d_mag;
  logic                    s2_p_neg, s2_i_neg, s2_d_neg;
  logic                    s2_p_hi, s2_p_lo, s2_i_hi, s2_i_lo;

  logic rdy1, rdy2, rdy3;
  logic in_xfer;

  // transfer-cycle arithmetic
  logic signed [ERR_W-1:0]  err, diff;
  logic signed [TENT_W-1:0] tent, elim, slim;
  logic                     p_hi, p_lo, i_hi, i_lo;

  // stage 2 combinational
  logic [ERR_W-1:0] p_mag, i_mag, d_mag;
  logic             p_neg, i_neg, d_neg;

  // stage 3 combinational
  logic signed [TERM_W-1:0] term_p, term_i, term_d, total;
  logic [DRIVE_W-1:0]       drive_next;

  // pipeline flow control
  assign rdy3     = !out_valid || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;
  assign in_xfer  = in_valid && rdy1;

  assign cfg_ready = 1'b1;

  // register writes, upper data bits dropped per register width
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain        <= PROP_GAIN_RST;
      integ_gain       <= INTEG_GAIN_RST;
      deriv_gain       <= DERIV_GAIN_RST;
      error_limit      <= ERROR_LIMIT_RST;
      sum_limit        <= SUM_LIMIT_RST;
      prop_saturation  <= PROP_SAT_RST;
      integ_saturation <= INTEG_SAT_RST;
      drive_max        <= DRIVE_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_PROP_GAIN:   prop_gain        <= cfg_data[GAIN_W-1:0];
        REG_INTEG_GAIN:  integ_gain       <= cfg_data[GAIN_W-1:0];
        REG_DERIV_GAIN:  deriv_gain       <= cfg_data[GAIN_W-1:0];
        REG_ERROR_LIMIT: error_limit      <= cfg_data[LIM_W-1:0];
        REG_SUM_LIMIT:   sum_limit        <= cfg_data[LIM_W-1:0];
        REG_PROP_SAT:    prop_saturation  <= cfg_data[LIM_W-1:0];
        REG_INTEG_SAT:   integ_saturation <= cfg_data[LIM_W-1:0];
        REG_DRIVE_MAX:   drive_max        <= cfg_data[DRIVE_W-1:0];
        default: ;
      endcase
    end
  end

  // error, tentative sum and limit checks straight from the input ports
  always_comb begin
    err  = ERR_W'($signed(set_point)) - ERR_W'($signed(measured));
    diff = ERR_W'(last_measured) - ERR_W'($signed(measured));
    elim = $signed({{(TENT_W-LIM_W){1'b0}}, error_limit});
    slim = $signed({{(TENT_W-LIM_W){1'b0}}, sum_limit});
    tent = TENT_W'(integral_sum) + TENT_W'(err);

    // strict compares: an error or sum exactly at the limit is not clamped
    p_hi = TENT_W'(err) > elim;
    p_lo = TENT_W'(err) < -elim;
    i_hi = tent > slim;
    i_lo = tent < -slim;

    if (i_hi) begin
      integral_sum_next = ERR_W'(slim);
    end else if (i_lo) begin
      integral_sum_next = ERR_W'(-slim);
    end else begin
      integral_sum_next = tent[ERR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum  <= '0;
      last_measured <= '0;
    end else if (in_xfer) begin
      integral_sum  <= integral_sum_next;
      last_measured <= $signed(measured);
    end
  end

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_err  <= err;
      s1_sum  <= integral_sum;   // integral term uses the sum before this sample
      s1_diff <= diff;
      s1_p_hi <= p_hi;
      s1_p_lo <= p_lo;
      s1_i_hi <= i_hi;
      s1_i_lo <= i_lo;
    end
  end

  // gain multiplies, one shared form for all three terms
  pdc_scale u_scale_p (
    .value (s1_err),
    .gain  (prop_gain),
    .mag   (p_mag),
    .neg   (p_neg)
  );

  pdc_scale u_scale_i (
    .value (s1_sum),
    .gain  (integ_gain),
    .mag   (i_mag),
    .neg   (i_neg)
  );

  pdc_scale u_scale_d (
    .value (s1_diff),
    .gain  (deriv_gain),
    .mag   (d_mag),
    .neg   (d_neg)
  );

  // stage 2 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1 && rdy2) begin
      s2_p_mag <= p_mag;
      s2_i_mag <= i_mag;
      s2_d_mag <= d_mag;
      s2_p_neg <= p_neg;
      s2_i_neg <= i_neg;
      s2_d_neg <= d_neg;
      s2_p_hi  <= s1_p_hi;
      s2_p_lo  <= s1_p_lo;
      s2_i_hi  <= s1_i_hi;
      s2_i_lo  <= s1_i_lo;
    end
  end

  // signed terms, saturation overrides, three-term sum and output clamp
  always_comb begin
    if (s2_p_hi) begin
      term_p = TERM_W'(prop_saturation);
    end else if (s2_p_lo) begin
      term_p = -TERM_W'(prop_saturation);
    end else begin
      term_p = s2_p_neg ? -TERM_W'(s2_p_mag) : TERM_W'(s2_p_mag);
    end

    // positive overflow saturates positive, negative overflow negative
    if (s2_i_hi) begin
      term_i = TERM_W'(integ_saturation);
    end else if (s2_i_lo) begin
      term_i = -TERM_W'(integ_saturation);
    end else begin
      term_i = s2_i_neg ? -TERM_W'(s2_i_mag) : TERM_W'(s2_i_mag);
    end

    term_d = s2_d_neg ? -TERM_W'(s2_d_mag) : TERM_W'(s2_d_mag);
    total  = term_p + term_i + term_d;

    if (total[TERM_W-1]) begin
      drive_next = '0;
    end else if (total > $signed(TERM_W'(drive_max))) begin
      drive_next = drive_max;
    end else begin
      drive_next = total[DRIVE_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy3) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && rdy3) begin
      drive <= drive_next;
    end
  end

endmodule

// ===== hw/rtl/pdc_scale.sv =====
// pdc_scale: signed value times unsigned q0.16 gain, rounded half away from zero
// returns magnitude and sign separately; depends on pdc_pkg
`timescale 1ns / 1ps

module pdc_scale import pdc_pkg::*; (
  input  logic signed [ERR_W-1:0]  value,
  input  logic        [GAIN_W-1:0] gain,
  output logic        [ERR_W-1:0]  mag,
  output logic                     neg
);

  logic [ERR_W-1:0]  abs_value;
  logic [PROD_W-1:0] prod;

  always_comb begin
    neg       = value[ERR_W-1];
    abs_value = neg ? ERR_W'(-value) : ERR_W'(value);
    prod      = PROD_W'(abs_value) * PROD_W'(gain) + ROUND_HALF;
    mag       = prod[PROD_W-1:GAIN_W];
  end

endmodule

// ===== hw/rtl/pdc_checker.sv =====
// pdc_checker: port-level checks for pid_drive_with_clamps, bound to the top
// depends on pdc_pkg
`timescale 1ns / 1ps

module pdc_checker import pdc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [DRIVE_W-1:0] drive,
  input logic               cfg_ready
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // with no result pending every stage is free, so input must be taken
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output");

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(drive))
    else $error("stalled result dropped or changed");

  // a transfer made while no result is pending passes the three register
  // stages and is then seen at the output
  a_latency: assert property (@(posedge clk) disable iff (rst)
    !out_valid && in_valid && in_ready |=> ##2 out_valid)
    else $error("result missing three edges after transfer");

  // register port never back-pressures
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind pid_drive_with_clamps pdc_checker u_pdc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .drive     (drive),
  .cfg_ready (cfg_ready)
);

// ===== sim/tb_pid_drive_with_clamps.sv =====
// tb_pid_drive_with_clamps: self-checking bench for the pid servo drive, with
// its own drive predictor, scoreboard and random traffic over several phases
// depends on pdc_pkg and pid_drive_with_clamps
`timescale 1ns / 1ps

module tb_pid_drive_with_clamps;
  import pdc_pkg::*;

  localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] DFLT_ERR_LIMIT = DATA_W'(ERROR_LIMIT_RST);

  // scoreboard: mirrors the register file and controller state, predicts the
  // drive of each accepted sample and checks results in order
  class drive_scoreboard;
    logic [GAIN_W-1:0]         prop_gain, integ_gain, deriv_gain;
    logic [LIM_W-1:0]          error_limit, sum_limit, prop_saturation, integ_saturation;
    logic [DRIVE_W-1:0]        drive_max;
    logic signed [ERR_W-1:0]   integral_sum;
    logic signed [DATA_W-1:0]  last_measured;
    logic [DRIVE_W-1:0]        expected_drive[$];
    int                        failures;

    function new();
      prop_gain        = PROP_GAIN_RST;
      integ_gain       = INTEG_GAIN_RST;
      deriv_gain       = DERIV_GAIN_RST;
      error_limit      = ERROR_LIMIT_RST;
      sum_limit        = SUM_LIMIT_RST;
      prop_saturation  = PROP_SAT_RST;
      integ_saturation = INTEG_SAT_RST;
      drive_max        = DRIVE_MAX_RST;
      integral_sum     = '0;
      last_measured    = '0;
      failures         = 0;
    endfunction

    function void write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] data);
      case (r)
        REG_PROP_GAIN:   prop_gain        = data[GAIN_W-1:0];
        REG_INTEG_GAIN:  integ_gain       = data[GAIN_W-1:0];
        REG_DERIV_GAIN:  deriv_gain       = data[GAIN_W-1:0];
        REG_ERROR_LIMIT: error_limit      = data[LIM_W-1:0];
        REG_SUM_LIMIT:   sum_limit        = data[LIM_W-1:0];
        REG_PROP_SAT:    prop_saturation  = data[LIM_W-1:0];
        REG_INTEG_SAT:   integ_saturation = data[LIM_W-1:0];
        REG_DRIVE_MAX:   drive_max        = data[DRIVE_W-1:0];
        default: ;
      endcase
    endfunction

    // value times q0.16 gain, round half away from zero
    function logic signed [TERM_W-1:0] scaled(logic signed [ERR_W-1:0] v,
                                              logic [GAIN_W-1:0] g);
      logic [ERR_W-1:0] mag;
      logic [PROD_W:0]  prod;
      mag  = (v < 0) ? -v : v;
      prod = mag * g + ROUND_HALF;
      prod = prod >> GAIN_W;
      return (v < 0) ? -$signed(TERM_W'(prod)) : $signed(TERM_W'(prod));
    endfunction

    function logic [DRIVE_W-1:0] predict_drive(logic signed [DATA_W-1:0] sp,
                                               logic signed [DATA_W-1:0] meas);
      logic signed [ERR_W-1:0]  err, slope;
      logic signed [TENT_W-1:0] elim, slim, tent;
      logic signed [TERM_W-1:0] p, i, d, total;
      err  = ERR_W'(sp) - ERR_W'(meas);
      elim = TENT_W'(error_limit);
      slim = TENT_W'(sum_limit);

      // strict compare: an error right at the limit still goes through the gain
      if (TENT_W'(err) > elim) p = TERM_W'(prop_saturation);
      else if (TENT_W'(err) < -elim) p = -TERM_W'(prop_saturation);
      else p = scaled(err, prop_gain);

      // anti-windup: clamp the sum, saturate the term in the overflow direction
      tent = TENT_W'(integral_sum) + TENT_W'(err);
      if (tent > slim) begin
        i            = TERM_W'(integ_saturation);
        integral_sum = ERR_W'(slim);
      end else if (tent < -slim) begin
        i            = -TERM_W'(integ_saturation);
        integral_sum = ERR_W'(-slim);
      end else begin
        i            = scaled(integral_sum, integ_gain);
        integral_sum = ERR_W'(tent);
      end

      // derivative on measurement only
      slope         = ERR_W'(last_measured) - ERR_W'(meas);
      d             = scaled(slope, deriv_gain);
      last_measured = meas;

      total = p + i + d;
      if (total < 0) return '0;
      if (total > $signed(TERM_W'(drive_max))) return drive_max;
      return total[DRIVE_W-1:0];
    endfunction

    function void note_sample(logic signed [DATA_W-1:0] sp, logic signed [DATA_W-1:0] meas);
      expected_drive.push_back(predict_drive(sp, meas));
    endfunction

    function void check_drive(logic [DRIVE_W-1:0] actual);
      logic [DRIVE_W-1:0] want;
      if (expected_drive.size() == 0) begin
        failures++;
        $display("%0t: drive %0d with no expected result", $time, actual);
        return;
      end
      want = expected_drive.pop_front();
      if (actual !== want) begin
        failures++;
        $display("%0t: drive mismatch, expected %0d, actual %0d", $time, want, actual);
      end
    endfunction

    function int pending();
      return expected_drive.size();
    endfunction
  endclass

  // dut signals, the driven ones known from time zero
  logic                  clk;
  logic                  rst        = 1'b1;
  logic                  in_valid   = 1'b0;
  logic                  in_ready;
  logic [DATA_W-1:0]     set_point  = '0;
  logic [DATA_W-1:0]     measured   = '0;
  logic                  out_valid;
  logic                  out_ready  = 1'b1;
  logic [DRIVE_W-1:0]    drive;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  cfg_reg_t              cfg_index  = REG_PROP_GAIN;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  // traffic knobs, percent of cycles spent idle on each side
  int                       send_idle_pct  = 0;
  int                       recv_stall_pct = 0;
  bit                       long_hold      = 1'b0;
  logic signed [DATA_W-1:0] track_meas     = '0;

  drive_scoreboard sb;

  pid_drive_with_clamps dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .set_point (set_point),
    .measured  (measured),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .drive     (drive),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop in case a transfer never completes
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // monitor: every transfer is sampled at the edge where it happens, so the
  // values seen are the ones from before the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (out_valid && out_ready) sb.check_drive(drive);
      if (in_valid && in_ready) sb.note_sample(set_point, measured);
    end
  end

  // receiver: random backpressure, plus an occasional long hold-off that lets
  // the pipeline fill and push back on the input
  initial begin : receiver
    int hold_count;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        long_hold  = 1'b0;
        hold_count = 200;
        while (hold_count > 0) begin
          out_ready <= 1'b0;
          @(posedge clk);
          hold_count--;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // one sample transfer; valid stays up between back-to-back samples
  task automatic send_sample(input logic [DATA_W-1:0] sp, input logic [DATA_W-1:0] meas);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid  <= 1'b1;
    set_point <= sp;
    measured  <= meas;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop offering and wait for every predicted drive to come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic cfg_write(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] value);
    int w;
    w = (r inside {REG_ERROR_LIMIT, REG_SUM_LIMIT, REG_PROP_SAT, REG_INTEG_SAT}) ?
        LIM_W : GAIN_W;
    cfg_valid <= 1'b1;
    cfg_index <= r;
    // junk above the register width, the block has to drop it
    cfg_data  <= value | ($urandom() << w);
    do @(posedge clk); while (!cfg_ready);
  endtask

  // full register load, only called with the pipeline empty
  task automatic load_regs(input logic [GAIN_W-1:0] p_gain, i_gain, d_gain,
                           input logic [LIM_W-1:0] err_lim, sum_lim, p_sat, i_sat,
                           input logic [DRIVE_W-1:0] d_max);
    cfg_write(REG_PROP_GAIN,   CFG_DATA_W'(p_gain));
    cfg_write(REG_INTEG_GAIN,  CFG_DATA_W'(i_gain));
    cfg_write(REG_DERIV_GAIN,  CFG_DATA_W'(d_gain));
    cfg_write(REG_ERROR_LIMIT, CFG_DATA_W'(err_lim));
    cfg_write(REG_SUM_LIMIT,   CFG_DATA_W'(sum_lim));
    cfg_write(REG_PROP_SAT,    CFG_DATA_W'(p_sat));
    cfg_write(REG_INTEG_SAT,   CFG_DATA_W'(i_sat));
    cfg_write(REG_DRIVE_MAX,   CFG_DATA_W'(d_max));
    cfg_valid <= 1'b0;
  endtask

  // limits spread over many magnitudes so every clamp gets a chance
  task automatic load_random_regs();
    load_regs(GAIN_W'($urandom_range(65535)), GAIN_W'($urandom_range(65535)),
              GAIN_W'($urandom_range(65535)),
              LIM_W'($urandom() >> $urandom_range(31, 1)),
              LIM_W'($urandom() >> $urandom_range(31, 1)),
              LIM_W'($urandom() >> $urandom_range(31, 1)),
              LIM_W'($urandom() >> $urandom_range(31, 1)),
              DRIVE_W'($urandom_range(65535)));
  endtask

  task automatic directed_samples();
    logic signed [TENT_W-1:0] aim;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_sample('0, '0);
    send_sample(32'sd25600, '0);                // 100.0 of error, drive in range
    send_sample(DATA_MAX, DATA_MIN);            // largest error, positive windup
    send_sample(DATA_MIN, DATA_MAX);            // most negative error, negative windup
    send_sample(32'h5555_5555, 32'hAAAA_AAAA);
    send_sample(32'hAAAA_AAAA, 32'h5555_5555);
    send_sample('0, DATA_MIN);
    send_sample(DATA_MIN, '0);
    // error right at the threshold and one past it, both signs
    send_sample(DFLT_ERR_LIMIT, '0);
    send_sample(DFLT_ERR_LIMIT + 1, '0);
    send_sample(-DFLT_ERR_LIMIT, '0);
    send_sample(-DFLT_ERR_LIMIT - 1, '0);
    // tentative sum landing exactly on +limit, then exactly on -limit
    drain();
    aim = TENT_W'(sb.sum_limit) - TENT_W'(sb.integral_sum);
    send_sample(aim[DATA_W-1:0], '0);
    drain();
    aim = -TENT_W'(sb.sum_limit) - TENT_W'(sb.integral_sum);
    send_sample(aim[DATA_W-1:0], '0);
    send_sample(-1, '0);                        // just past -limit
    // small moves through the linear region, derivative kicks in
    send_sample(32'sd10240, 32'sd5120);
    send_sample(32'sd10240, 32'sd7680);
    send_sample(32'sd11520, 32'sd11520);
    send_sample(-32'sd2560, 32'sd15360);
    // leave the sum parked at +limit for the limit change that follows
    send_sample(DATA_MAX, '0);
    track_meas = '0;
  endtask

  task automatic random_sample();
    logic signed [DATA_W-1:0] meas, err;
    logic signed [TENT_W-1:0] aim;
    int kind;
    kind = $urandom_range(99);
    meas = track_meas + ($signed($urandom()) >>> $urandom_range(31, 10));
    if (kind < 20) begin
      // raw noise over both fields
      meas = $urandom();
      err  = $urandom();
    end else if (kind < 45) begin
      err = $signed($urandom()) >>> $urandom_range(31, 4);
    end else if (kind < 65) begin
      // around the proportional threshold
      aim = TENT_W'(sb.error_limit) + TENT_W'($urandom_range(2)) - TENT_W'(1);
      if ($urandom_range(1)) aim = -aim;
      err = aim[DATA_W-1:0];
    end else if (kind < 80) begin
      // aim the running sum at one of its clamps
      if ($urandom_range(1)) aim = TENT_W'(sb.sum_limit) - TENT_W'(sb.integral_sum);
      else aim = -TENT_W'(sb.sum_limit) - TENT_W'(sb.integral_sum);
      aim = aim + TENT_W'($urandom_range(4)) - TENT_W'(2);
      err = aim[DATA_W-1:0];
    end else begin
      err = $signed($urandom()) >>> 22;
    end
    track_meas = meas;
    send_sample(meas + err, meas);
  endtask

  task automatic random_phase(input int count, input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (count) random_sample();
  endtask

  initial begin : stimulus
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_samples();
    drain();

    // sum limit shrinks under a sum parked at the old limit
    load_regs(PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST, ERROR_LIMIT_RST,
              31'd65536, PROP_SAT_RST, INTEG_SAT_RST, DRIVE_MAX_RST);
    random_phase(66, 0, 0);
    drain();

    // every register at its top value, sender mostly idle
    load_regs('1, '1, '1, '1, '1, '1, '1, '1);
    random_phase(66, 83, 0);
    drain();

    // every register at zero, receiver mostly stalled
    load_regs('0, '0, '0, '0, '0, '0, '0, '0);
    random_phase(66, 0, 83);
    drain();

    load_random_regs();
    random_phase(66, 28, 28);
    drain();

    // long receiver hold-off while the sender keeps pushing
    load_random_regs();
    long_hold = 1'b1;
    random_phase(66, 0, 0);
    drain();

    // sender pauses mid-phase until everything has come back
    load_random_regs();
    random_phase(33, 83, 0);
    drain();
    random_phase(33, 83, 0);
    drain();

    load_random_regs();
    random_phase(66, 0, 83);
    drain();

    load_regs(PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST, ERROR_LIMIT_RST,
              SUM_LIMIT_RST, PROP_SAT_RST, INTEG_SAT_RST, DRIVE_MAX_RST);
    random_phase(66, 28, 28);
    drain();

    // run on past the drain so a stray extra result would still be caught
    repeat (6) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
